/* sv/dpd_pkg.sv */
// Shared types and constants for the debug packet deframer.
`timescale 1ns / 1ps

package dpd_pkg;

  // Link characters
  localparam logic [7:0] CharStart = 8'h24;  // '$'
  localparam logic [7:0] CharEnd   = 8'h23;  // '#'
  localparam logic [7:0] CharAck   = 8'h2B;  // '+'
  localparam logic [7:0] CharNak   = 8'h2D;  // '-'
  localparam logic [7:0] CharSep   = 8'h3A;  // ':'

  // Result destinations
  localparam logic [1:0] DestLink    = 2'd0;
  localparam logic [1:0] DestPayload = 2'd1;
  localparam logic [1:0] DestVerdict = 2'd2;

  // Most results one received byte can produce
  localparam int MaxResults = 4;

  typedef logic [$clog2(MaxResults+1)-1:0] count_t;
  typedef logic [$clog2(MaxResults)-1:0]   slot_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_BODY,
    PH_HIGH,
    PH_LOW
  } phase_t;

  typedef struct packed {
    logic [1:0] dest;
    logic [7:0] data;
    logic       ok;
  } result_t;

  // All results caused by one received byte
  typedef struct packed {
    result_t [MaxResults-1:0] entries;
    count_t                   count;
  } batch_t;

endpackage

/* sv/dpd_parser.sv */
// Framing state machine: checksum, id prefix handling and result generation.
`timescale 1ns / 1ps

module dpd_parser (
  input  logic           clk,
  input  logic           rst,
  input  logic           take,
  input  logic [7:0]     rx_byte,
  output dpd_pkg::batch_t batch
);

  dpd_pkg::phase_t phase, phase_next;
  logic [7:0] running_sum, running_sum_next;
  logic [3:0] high_nibble, high_nibble_next;
  logic       high_bad, high_bad_next;
  logic [1:0] prefix_count, prefix_count_next;
  logic       seq_seen, seq_seen_next;
  logic [7:0] held0, held0_next;
  logic [7:0] held1, held1_next;

  logic [7:0] sum_plus;
  logic [4:0] digit;
  logic       sum_ok;

  // Hex digit value; bit 4 set means not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] v;
    v = 5'h10;
    if (b >= 8'h30 && b <= 8'h39) v = {1'b0, 4'(b - 8'h30)};
    else if (b >= 8'h61 && b <= 8'h66) v = {1'b0, 4'(b - 8'h57)};
    else if (b >= 8'h41 && b <= 8'h46) v = {1'b0, 4'(b - 8'h37)};
    return v;
  endfunction

  assign sum_plus = running_sum + rx_byte;
  assign digit    = hex_value(rx_byte);
  assign sum_ok   = !high_bad && !digit[4] && ({high_nibble, digit[3:0]} == running_sum);

  // Next phase
  always_comb begin
    phase_next = phase;
    case (phase)
      dpd_pkg::PH_IDLE: if (rx_byte == dpd_pkg::CharStart) phase_next = dpd_pkg::PH_BODY;
      dpd_pkg::PH_BODY: if (rx_byte == dpd_pkg::CharEnd) phase_next = dpd_pkg::PH_HIGH;
      dpd_pkg::PH_HIGH: phase_next = dpd_pkg::PH_LOW;
      dpd_pkg::PH_LOW:  phase_next = dpd_pkg::PH_IDLE;
      default:          phase_next = dpd_pkg::PH_IDLE;
    endcase
  end

  // Datapath updates and results
  always_comb begin
    running_sum_next  = running_sum;
    high_nibble_next  = high_nibble;
    high_bad_next     = high_bad;
    prefix_count_next = prefix_count;
    seq_seen_next     = seq_seen;
    held0_next        = held0;
    held1_next        = held1;
    batch             = '0;
    case (phase)
      dpd_pkg::PH_IDLE: begin
        if (rx_byte == dpd_pkg::CharStart) begin
          running_sum_next  = '0;
          prefix_count_next = '0;
          seq_seen_next     = 1'b0;
          high_bad_next     = 1'b0;
          high_nibble_next  = '0;
        end
      end
      dpd_pkg::PH_BODY: begin
        if (rx_byte == dpd_pkg::CharEnd) begin
          // short payload: flush whatever is held
          if (prefix_count == 2'd1) begin
            batch.entries[0] = '{dpd_pkg::DestPayload, held0, 1'b0};
            batch.count      = dpd_pkg::count_t'(1);
          end else if (prefix_count == 2'd2) begin
            batch.entries[0] = '{dpd_pkg::DestPayload, held0, 1'b0};
            batch.entries[1] = '{dpd_pkg::DestPayload, held1, 1'b0};
            batch.count      = dpd_pkg::count_t'(2);
          end
        end else begin
          running_sum_next = sum_plus;
          case (prefix_count)
            2'd0: begin
              held0_next        = rx_byte;
              prefix_count_next = 2'd1;
            end
            2'd1: begin
              held1_next        = rx_byte;
              prefix_count_next = 2'd2;
            end
            2'd2: begin
              prefix_count_next = 2'd3;
              if (rx_byte == dpd_pkg::CharSep) begin
                seq_seen_next = 1'b1;
              end else begin
                batch.entries[0] = '{dpd_pkg::DestPayload, held0, 1'b0};
                batch.entries[1] = '{dpd_pkg::DestPayload, held1, 1'b0};
                batch.entries[2] = '{dpd_pkg::DestPayload, rx_byte, 1'b0};
                batch.count      = dpd_pkg::count_t'(3);
              end
            end
            default: begin
              batch.entries[0] = '{dpd_pkg::DestPayload, rx_byte, 1'b0};
              batch.count      = dpd_pkg::count_t'(1);
            end
          endcase
        end
      end
      dpd_pkg::PH_HIGH: begin
        high_bad_next    = digit[4];
        high_nibble_next = digit[3:0];
      end
      default: begin
        // low digit: reply, optional id echo, verdict
        if (sum_ok) begin
          batch.entries[0] = '{dpd_pkg::DestLink, dpd_pkg::CharAck, 1'b0};
          if (seq_seen) begin
            batch.entries[1] = '{dpd_pkg::DestLink, held0, 1'b0};
            batch.entries[2] = '{dpd_pkg::DestLink, held1, 1'b0};
            batch.entries[3] = '{dpd_pkg::DestVerdict, 8'h00, 1'b1};
            batch.count      = dpd_pkg::count_t'(4);
          end else begin
            batch.entries[1] = '{dpd_pkg::DestVerdict, 8'h00, 1'b1};
            batch.count      = dpd_pkg::count_t'(2);
          end
        end else begin
          batch.entries[0] = '{dpd_pkg::DestLink, dpd_pkg::CharNak, 1'b0};
          batch.entries[1] = '{dpd_pkg::DestVerdict, 8'h00, 1'b0};
          batch.count      = dpd_pkg::count_t'(2);
        end
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= dpd_pkg::PH_IDLE;
      running_sum  <= '0;
      high_nibble  <= '0;
      high_bad     <= 1'b0;
      prefix_count <= '0;
      seq_seen     <= 1'b0;
    end else if (take) begin
      phase        <= phase_next;
      running_sum  <= running_sum_next;
      high_nibble  <= high_nibble_next;
      high_bad     <= high_bad_next;
      prefix_count <= prefix_count_next;
      seq_seen     <= seq_seen_next;
    end
  end

  // Held prefix bytes
  always_ff @(posedge clk) begin
    if (take) begin
      held0 <= held0_next;
      held1 <= held1_next;
    end
  end

endmodule

/* sv/dpd_serializer.sv */
// Result register: holds one byte's results and sends them one per transfer.
`timescale 1ns / 1ps

module dpd_serializer (
  input  logic            clk,
  input  logic            rst,
  input  logic            rx_valid,
  output logic            rx_stall,
  input  dpd_pkg::batch_t batch,
  output logic            take,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [1:0]      dest,
  output logic [7:0]      data,
  output logic            checksum_ok,
  output logic            last
);

  dpd_pkg::result_t [dpd_pkg::MaxResults-1:0] entries;
  dpd_pkg::count_t cnt;
  dpd_pkg::slot_t  idx;
  logic busy, at_last, fin, room;

  assign busy    = (cnt != '0);
  assign at_last = ({1'b0, idx} == dpd_pkg::count_t'(cnt - dpd_pkg::count_t'(1)));
  assign fin     = busy && !out_stall && at_last;
  assign room    = !busy || fin;
  assign rx_stall = !room;
  assign take     = rx_valid && room;

  assign out_valid   = busy;
  assign dest        = entries[idx].dest;
  assign data        = entries[idx].data;
  assign checksum_ok = entries[idx].ok;
  assign last        = at_last;

  // Slot counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      idx <= '0;
    end else if (take) begin
      cnt <= batch.count;
      idx <= '0;
    end else if (fin) begin
      cnt <= '0;
      idx <= '0;
    end else if (busy && !out_stall) begin
      idx <= idx + dpd_pkg::slot_t'(1);
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (take) begin
      entries <= batch.entries;
    end
  end

endmodule

/* sv/debug_packet_deframer.sv */
// Top level of the debug packet deframer.
`timescale 1ns / 1ps

// Takes one link byte per transfer and returns 0 to 4 results per byte: link
// replies ('+', '-', echoed sequence id), payload bytes and a closing verdict
// per packet. A byte's results are computed in the cycle it is accepted and
// come out one per unstalled cycle from the result register; the next byte
// is accepted in the cycle the last result of the previous one is taken.
// Bytes with no results flow at one per cycle; a byte with results holds the
// input until its last one is taken, so the single-result port sets the rate.

module debug_packet_deframer (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] dest,
  output logic [7:0] data,
  output logic       checksum_ok,
  output logic       last
);

  dpd_pkg::batch_t batch;
  logic take;

  // Framing and checksum
  dpd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .rx_byte (rx_byte),
    .batch   (batch)
  );

  // Output sequencing
  dpd_serializer u_serializer (
    .clk         (clk),
    .rst         (rst),
    .rx_valid    (rx_valid),
    .rx_stall    (rx_stall),
    .batch       (batch),
    .take        (take),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .dest        (dest),
    .data        (data),
    .checksum_ok (checksum_ok),
    .last        (last)
  );

endmodule

/* tb/sv/debug_packet_deframer_test.sv */
// Testbench for the debug packet deframer: framed packets in, link, payload and verdict checked.
`timescale 1ns / 1ps

module debug_packet_deframer_test;

  // One result as seen on the output port
  typedef struct {
    logic [1:0] dest;
    logic [7:0] data;
    logic       ok;
    logic       last;
  } link_result_t;

  // How the two checksum characters of a packet are formed
  typedef enum int {
    CK_LOWER,
    CK_UPPER,
    CK_WRONG,
    CK_BAD_HIGH,
    CK_BAD_LOW,
    CK_RANDOM
  } checksum_style_t;

  // Tracks the packet parser and holds the results still owed by the block
  class deframer_scoreboard;
    link_result_t     owed_results[$];
    int               failures;
    dpd_pkg::phase_t  phase;
    logic [7:0]       running_sum;
    logic [3:0]       high_nibble;
    logic             high_bad;
    logic [1:0]       prefix_count;
    logic [7:0]       held[2];
    logic             id_seen;

    function new();
      failures     = 0;
      phase        = dpd_pkg::PH_IDLE;
      running_sum  = '0;
      high_nibble  = '0;
      high_bad     = 1'b0;
      prefix_count = '0;
      held[0]      = '0;
      held[1]      = '0;
      id_seen      = 1'b0;
    endfunction

    // Digit value, or 16 when the byte is not a hex digit
    function logic [4:0] hex_value(logic [7:0] b);
      if (b >= 8'h30 && b <= 8'h39) return 5'(b - 8'h30);
      if (b >= 8'h61 && b <= 8'h66) return 5'(b - 8'h61 + 8'd10);
      if (b >= 8'h41 && b <= 8'h46) return 5'(b - 8'h41 + 8'd10);
      return 5'd16;
    endfunction

    function void owe(logic [1:0] dest, logic [7:0] data, logic ok);
      link_result_t r;
      r.dest = dest;
      r.data = data;
      r.ok   = ok;
      r.last = 1'b0;
      owed_results.push_back(r);
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    // Advance the parser by one accepted byte and queue what it produces
    function void take_rx_byte(logic [7:0] b);
      int           before_count;
      logic [4:0]   d;
      logic         good;
      link_result_t tail;
      before_count = owed_results.size();
      case (phase)
        dpd_pkg::PH_IDLE: begin
          if (b == dpd_pkg::CharStart) begin
            phase        = dpd_pkg::PH_BODY;
            running_sum  = '0;
            prefix_count = '0;
            id_seen      = 1'b0;
            high_bad     = 1'b0;
            high_nibble  = '0;
          end
        end
        dpd_pkg::PH_BODY: begin
          if (b == dpd_pkg::CharEnd) begin
            // short payload: flush whatever was held back
            if (prefix_count == 2'd1 || prefix_count == 2'd2)
              owe(dpd_pkg::DestPayload, held[0], 1'b0);
            if (prefix_count == 2'd2) owe(dpd_pkg::DestPayload, held[1], 1'b0);
            phase = dpd_pkg::PH_HIGH;
          end else begin
            running_sum = running_sum + b;
            if (prefix_count < 2'd2) begin
              held[prefix_count[0]] = b;
              prefix_count = prefix_count + 2'd1;
            end else if (prefix_count == 2'd2) begin
              prefix_count = 2'd3;
              if (b == dpd_pkg::CharSep) begin
                id_seen = 1'b1;
              end else begin
                owe(dpd_pkg::DestPayload, held[0], 1'b0);
                owe(dpd_pkg::DestPayload, held[1], 1'b0);
                owe(dpd_pkg::DestPayload, b, 1'b0);
              end
            end else begin
              owe(dpd_pkg::DestPayload, b, 1'b0);
            end
          end
        end
        dpd_pkg::PH_HIGH: begin
          d           = hex_value(b);
          high_bad    = d[4];
          high_nibble = d[3:0];
          phase       = dpd_pkg::PH_LOW;
        end
        default: begin
          d    = hex_value(b);
          good = !high_bad && !d[4] && ({high_nibble, d[3:0]} == running_sum);
          if (good) begin
            owe(dpd_pkg::DestLink, dpd_pkg::CharAck, 1'b0);
            if (id_seen) begin
              owe(dpd_pkg::DestLink, held[0], 1'b0);
              owe(dpd_pkg::DestLink, held[1], 1'b0);
            end
          end else begin
            owe(dpd_pkg::DestLink, dpd_pkg::CharNak, 1'b0);
          end
          owe(dpd_pkg::DestVerdict, 8'h00, good);
          phase = dpd_pkg::PH_IDLE;
        end
      endcase
      // mark the final result of this byte
      if (owed_results.size() > before_count) begin
        tail      = owed_results.pop_back();
        tail.last = 1'b1;
        owed_results.push_back(tail);
      end
    endfunction

    function void note_failure(string msg);
      failures++;
      if (failures <= 10) $display("mismatch: %s", msg);
    endfunction

    // Compare one transfer from the block with the oldest owed result
    function void check_result(logic [1:0] dest, logic [7:0] data, logic ok, logic last);
      link_result_t want;
      if (owed_results.size() == 0) begin
        note_failure($sformatf("unexpected result dest=%0d data=%02h ok=%0d last=%0d",
                               dest, data, ok, last));
        return;
      end
      want = owed_results.pop_front();
      if (want.dest !== dest || want.data !== data || want.ok !== ok || want.last !== last)
        note_failure($sformatf(
          "expected dest=%0d data=%02h ok=%0d last=%0d, got dest=%0d data=%02h ok=%0d last=%0d",
          want.dest, want.data, want.ok, want.last, dest, data, ok, last));
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       rx_valid = 1'b0;
  logic       rx_stall;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] dest;
  logic [7:0] data;
  logic       checksum_ok;
  logic       last;

  int idle_pct = 0;
  int stall_pct = 0;
  int sent_bytes = 0;

  deframer_scoreboard sb;

  debug_packet_deframer dut (
    .clk        (clk),
    .rst        (rst),
    .rx_valid   (rx_valid),
    .rx_stall   (rx_stall),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .dest       (dest),
    .data       (data),
    .checksum_ok(checksum_ok),
    .last       (last)
  );

  always #5 clk = ~clk;

  // Receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(dest, data, checksum_ok, last);
  end

  function automatic logic [7:0] hex_char(logic [3:0] nibble, bit upper);
    if (nibble < 4'd10) return 8'h30 + 8'(nibble);
    return (upper ? 8'h41 : 8'h61) + 8'(nibble) - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex_byte();
    logic [7:0] b;
    logic [4:0] v;
    do begin
      b = 8'($urandom);
      v = sb.hex_value(b);
    end while (!v[4]);
    return b;
  endfunction

  // One byte transfer, with random idle cycles in front
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < idle_pct) begin
      rx_valid <= 1'b0;
      rx_byte  <= 8'($urandom);
      @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (rx_stall) @(posedge clk);
    sb.take_rx_byte(b);
    sent_bytes++;
  endtask

  // Full frame: start marker, body, end marker, two checksum characters
  task automatic send_packet(input logic [7:0] body[$], input checksum_style_t style);
    logic [7:0] sum;
    logic [7:0] hi;
    logic [7:0] lo;
    bit         upper;
    sum   = '0;
    upper = (style == CK_UPPER);
    foreach (body[i]) sum = sum + body[i];
    if (style == CK_WRONG) sum = sum + 8'($urandom_range(1, 255));
    hi = hex_char(sum[7:4], upper);
    lo = hex_char(sum[3:0], upper);
    case (style)
      CK_BAD_HIGH: hi = non_hex_byte();
      CK_BAD_LOW:  lo = non_hex_byte();
      CK_RANDOM: begin
        hi = 8'($urandom);
        lo = 8'($urandom);
      end
      default: ;
    endcase
    send_byte(dpd_pkg::CharStart);
    foreach (body[i]) send_byte(body[i]);
    send_byte(dpd_pkg::CharEnd);
    send_byte(hi);
    send_byte(lo);
  endtask

  // Mostly well-formed frames with random content, some line noise and bad checksums
  task automatic random_packet();
    logic [7:0]      body[$];
    logic [7:0]      b;
    int              len;
    int              pick;
    checksum_style_t style;
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
    end
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        b = dpd_pkg::CharStart;
      end else begin
        do b = 8'($urandom); while (b == dpd_pkg::CharEnd);
      end
      body.push_back(b);
    end
    if (len >= 3 && $urandom_range(0, 2) == 0) body[2] = dpd_pkg::CharSep;
    pick = $urandom_range(0, 99);
    if (pick < 35) style = CK_LOWER;
    else if (pick < 65) style = CK_UPPER;
    else if (pick < 75) style = CK_WRONG;
    else if (pick < 83) style = CK_BAD_HIGH;
    else if (pick < 91) style = CK_BAD_LOW;
    else style = CK_RANDOM;
    send_packet(body, style);
  endtask

  initial begin
    #2ms;
    $display("debug_packet_deframer_test NOT OK");
    $finish;
  end

  initial begin
    logic [7:0] body[$];
    int         idle_by_phase[4];
    int         stall_by_phase[4];
    int         target;
    idle_by_phase  = '{0, 80, 0, 21};
    stall_by_phase = '{0, 0, 80, 21};
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: noise while idle, empty body, id with '$' inside, short wrong sum, non-hex digit
    send_byte(8'h00);
    send_byte(8'hFF);
    body.delete();
    send_packet(body, CK_LOWER);
    body = {8'h31, 8'h32, dpd_pkg::CharSep, dpd_pkg::CharStart};
    send_packet(body, CK_UPPER);
    body = {8'h41, 8'h42};
    send_packet(body, CK_WRONG);
    body = {8'h7A};
    send_packet(body, CK_BAD_HIGH);

    // Random frames under each idling mix
    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_by_phase[p];
      stall_pct = stall_by_phase[p];
      target    = sent_bytes + 95;
      while (sent_bytes < target) random_packet();
    end

    rx_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.failures == 0) begin
      $display("debug_packet_deframer_test OK");
    end else begin
      $display("debug_packet_deframer_test NOT OK");
    end
    $finish;
  end

endmodule

/* files.f */
sv/dpd_pkg.sv
sv/dpd_parser.sv
sv/dpd_serializer.sv
sv/debug_packet_deframer.sv
tb/sv/debug_packet_deframer_test.sv
